// ----- rtl/core/joystick_axis_center_calibration_defines.svh -----
// Assertion macros used by the joystick axis calibration top level
`ifndef JOYSTICK_AXIS_CENTER_CALIBRATION_DEFINES_SVH
`define JOYSTICK_AXIS_CENTER_CALIBRATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define JACC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define JACC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/jacc_pkg.sv -----
// Package: widths, register map, reset values and word types of the calibration block
`timescale 1ns / 1ps

package jacc_pkg;

    // sample and result width
    localparam int SAMPLE_BITS = 12;
    // numerator holds a sample difference times 2^(SAMPLE_BITS-1), or 2^(SAMPLE_BITS-1)-1 above neutral
    localparam int NUM_W       = 2 * SAMPLE_BITS - 1;
    // quotient bits kept; anything larger saturates
    localparam int QUO_W       = SAMPLE_BITS - 1;

    localparam int NUM_REGS    = 6;
    localparam int ADDR_W      = $clog2(4 * NUM_REGS);
    localparam int REG_IDX_W   = ADDR_W - 2;
    localparam int DATA_W      = 32;

    // queue between front and back
    localparam int Q_DEPTH     = 4;
    localparam int Q_IDX_W     = $clog2(Q_DEPTH);

    localparam logic [SAMPLE_BITS-1:0] CENTER_OUT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] FULL_OUT   = {SAMPLE_BITS{1'b1}};

    // register reset values
    localparam logic [SAMPLE_BITS-1:0] X_MIN_RST = SAMPLE_BITS'(4);
    localparam logic [SAMPLE_BITS-1:0] X_NEU_RST = SAMPLE_BITS'(627);
    localparam logic [SAMPLE_BITS-1:0] X_MAX_RST = SAMPLE_BITS'(1235);
    localparam logic [SAMPLE_BITS-1:0] Y_MIN_RST = SAMPLE_BITS'(598);
    localparam logic [SAMPLE_BITS-1:0] Y_NEU_RST = SAMPLE_BITS'(627);
    localparam logic [SAMPLE_BITS-1:0] Y_MAX_RST = SAMPLE_BITS'(904);

    // register map, word index = paddr / 4
    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_MIN,
        REG_X_NEU,
        REG_X_MAX,
        REG_Y_MIN,
        REG_Y_NEU,
        REG_Y_MAX
    } reg_idx_t;

    // calibration set handed to the front
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x_min;
        logic [SAMPLE_BITS-1:0] x_neu;
        logic [SAMPLE_BITS-1:0] x_max;
        logic [SAMPLE_BITS-1:0] y_min;
        logic [SAMPLE_BITS-1:0] y_neu;
        logic [SAMPLE_BITS-1:0] y_max;
    } cal_t;

    // one axis as prepared for division
    typedef struct packed {
        logic                   upper;   // sample at or above neutral
        logic                   center;  // divisor zero or negative
        logic [NUM_W-1:0]       num;
        logic [SAMPLE_BITS-1:0] div;
    } axis_work_t;

    // word carried through the queue
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lim_x;
        logic [SAMPLE_BITS-1:0] lim_y;
        axis_work_t             ax;
        axis_work_t             ay;
    } work_t;

    // one axis inside the divider pipeline
    typedef struct packed {
        logic                   upper;
        logic                   center;
        logic                   ovf;
        logic [NUM_W-1:0]       rem;
        logic [SAMPLE_BITS-1:0] div;
        logic [QUO_W-1:0]       quo;
    } div_lane_t;

    // front status
    typedef struct packed {
        logic valid;   // word held in the front register
        logic push;    // word moves into the queue this cycle
    } fr_stat_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/core/jacc_front.sv -----
// Front: accepts a sample pair, clamps it and sets up numerator and divisor per axis
`timescale 1ns / 1ps

module jacc_front
    import jacc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] raw_x,
    input  logic [SAMPLE_BITS-1:0] raw_y,
    input  cal_t                   cal,
    input  q_stat_t                q_stat,
    output fr_stat_t               fr_stat,
    output work_t                  word
);

    logic  valid_reg;
    logic  valid_next;
    work_t word_reg;
    work_t word_next;
    logic  accept;

    // maximum first, then minimum
    function automatic logic [SAMPLE_BITS-1:0] clamp_axis(
        input logic [SAMPLE_BITS-1:0] s,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi
    );
        logic [SAMPLE_BITS-1:0] v;
        v = (s > hi) ? hi : s;
        v = (v < lo) ? lo : v;
        return v;
    endfunction

    // pick branch; scale by 2^(N-1)-1 above neutral, 2^(N-1) below
    function automatic axis_work_t setup_axis(
        input logic [SAMPLE_BITS-1:0] lim,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] mid,
        input logic [SAMPLE_BITS-1:0] hi
    );
        axis_work_t             w;
        logic [SAMPLE_BITS-1:0] d;
        w = '0;
        if (lim >= mid)
        begin
            d        = lim - mid;
            w.upper  = 1'b1;
            w.center = (hi <= mid);
            w.div    = hi - mid;
            w.num    = (NUM_W'(d) << (SAMPLE_BITS - 1)) - NUM_W'(d);
        end
        else
        begin
            d        = lim - lo;
            w.upper  = 1'b0;
            w.center = (mid <= lo);
            w.div    = mid - lo;
            w.num    = NUM_W'(d) << (SAMPLE_BITS - 1);
        end
        return w;
    endfunction

    assign fr_stat.valid = valid_reg;
    assign fr_stat.push  = valid_reg && !q_stat.full;
    assign busy          = valid_reg && q_stat.full;
    assign accept        = start && !busy;
    assign word          = word_reg;

    // new word from the sample pair
    always_comb
    begin
        word_next.lim_x = clamp_axis(raw_x, cal.x_min, cal.x_max);
        word_next.lim_y = clamp_axis(raw_y, cal.y_min, cal.y_max);
        word_next.ax    = setup_axis(word_next.lim_x, cal.x_min, cal.x_neu, cal.x_max);
        word_next.ay    = setup_axis(word_next.lim_y, cal.y_min, cal.y_neu, cal.y_max);
    end

    // hold flag: set on accept, cleared once pushed
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fr_stat.push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ----- rtl/core/jacc_queue.sv -----
// Short queue of prepared words between front and back
`timescale 1ns / 1ps

module jacc_queue
    import jacc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fr_stat_t fr_stat,
    input  work_t    wr_word,
    input  logic     pop,
    output work_t    rd_word,
    output q_stat_t  q_stat
);

    work_t            entry_reg [Q_DEPTH];
    logic [Q_IDX_W:0] wr_ptr_reg;
    logic [Q_IDX_W:0] wr_ptr_next;
    logic [Q_IDX_W:0] rd_ptr_reg;
    logic [Q_IDX_W:0] rd_ptr_next;

    // pointers carry one wrap bit above the index
    assign q_stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_stat.full  = (wr_ptr_reg[Q_IDX_W] != rd_ptr_reg[Q_IDX_W]) &&
                          (wr_ptr_reg[Q_IDX_W-1:0] == rd_ptr_reg[Q_IDX_W-1:0]);
    assign rd_word      = entry_reg[rd_ptr_reg[Q_IDX_W-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (fr_stat.push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (fr_stat.push)
        begin
            entry_reg[wr_ptr_reg[Q_IDX_W-1:0]] <= wr_word;
        end
    end

endmodule

// ----- rtl/core/jacc_back.sv -----
// Back: pipelined restoring divider for both axes, one quotient bit per stage
`timescale 1ns / 1ps

module jacc_back
    import jacc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  q_stat_t                q_stat,
    input  work_t                  rd_word,
    output logic                   pop,
    output logic                   done,
    output logic [SAMPLE_BITS-1:0] limited_x,
    output logic [SAMPLE_BITS-1:0] limited_y,
    output logic [SAMPLE_BITS-1:0] scaled_x,
    output logic [SAMPLE_BITS-1:0] scaled_y
);

    logic                   valid_reg [QUO_W+1];
    logic [SAMPLE_BITS-1:0] lim_x_reg [QUO_W+1];
    logic [SAMPLE_BITS-1:0] lim_y_reg [QUO_W+1];
    div_lane_t              lane_x_reg [QUO_W+1];
    div_lane_t              lane_y_reg [QUO_W+1];

    logic                   done_reg;
    logic [SAMPLE_BITS-1:0] limited_x_reg;
    logic [SAMPLE_BITS-1:0] limited_y_reg;
    logic [SAMPLE_BITS-1:0] scaled_x_reg;
    logic [SAMPLE_BITS-1:0] scaled_y_reg;

    // entry: anything at or above div * 2^QUO_W saturates
    function automatic div_lane_t load_lane(input axis_work_t w);
        div_lane_t l;
        l.upper  = w.upper;
        l.center = w.center;
        l.ovf    = (w.num >= (NUM_W'(w.div) << QUO_W));
        l.rem    = w.num;
        l.div    = w.div;
        l.quo    = '0;
        return l;
    endfunction

    // one restoring step for quotient bit k
    function automatic div_lane_t div_step(input div_lane_t l, input int k);
        div_lane_t        r;
        logic [NUM_W-1:0] trial;
        r     = l;
        trial = NUM_W'(l.div) << k;
        if (l.rem >= trial)
        begin
            r.rem = l.rem - trial;
            r.quo = l.quo | (QUO_W'(1) << k);
        end
        return r;
    endfunction

    // final mapping onto 0..full scale
    function automatic logic [SAMPLE_BITS-1:0] finish_lane(input div_lane_t l);
        logic [SAMPLE_BITS-1:0] v;
        if (l.center)
        begin
            v = CENTER_OUT;
        end
        else if (l.ovf)
        begin
            v = FULL_OUT;
        end
        else if (l.upper)
        begin
            v = CENTER_OUT | SAMPLE_BITS'(l.quo);
        end
        else
        begin
            v = SAMPLE_BITS'(l.quo);
        end
        return v;
    endfunction

    // the back never stalls, so it drains the queue every cycle
    assign pop       = !q_stat.empty;
    assign done      = done_reg;
    assign limited_x = limited_x_reg;
    assign limited_y = limited_y_reg;
    assign scaled_x  = scaled_x_reg;
    assign scaled_y  = scaled_y_reg;

    // stage valid flags and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUO_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= pop;
            for (int i = 1; i <= QUO_W; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
            done_reg <= valid_reg[QUO_W];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        lim_x_reg[0]  <= rd_word.lim_x;
        lim_y_reg[0]  <= rd_word.lim_y;
        lane_x_reg[0] <= load_lane(rd_word.ax);
        lane_y_reg[0] <= load_lane(rd_word.ay);
        for (int i = 1; i <= QUO_W; i++)
        begin
            lim_x_reg[i]  <= lim_x_reg[i-1];
            lim_y_reg[i]  <= lim_y_reg[i-1];
            lane_x_reg[i] <= div_step(lane_x_reg[i-1], QUO_W - i);
            lane_y_reg[i] <= div_step(lane_y_reg[i-1], QUO_W - i);
        end
        limited_x_reg <= lim_x_reg[QUO_W];
        limited_y_reg <= lim_y_reg[QUO_W];
        scaled_x_reg  <= finish_lane(lane_x_reg[QUO_W]);
        scaled_y_reg  <= finish_lane(lane_y_reg[QUO_W]);
    end

endmodule

// ----- rtl/core/joystick_axis_center_calibration.sv -----
// Top level: calibration registers, front, queue and divider back end
//
// Use: raise start with raw_x/raw_y; the pair is taken on a rising edge where
// start is high and busy is low. Each pair gives one word on limited_x,
// limited_y, scaled_x and scaled_y, shown for one cycle with done high.
// Path: the result is registered through the front register, queue, entry stage,
// 11 divider stages and output register.
// Throughput: one pair per cycle while busy is low; the divider is fully pipelined with one
// quotient bit per stage for each axis.
// busy rises only if the queue is full while the front holds a word; the
// back end drains the queue every cycle, so in practice busy stays low.
// The receiver cannot stall: every result word is shown exactly once.
// Calibration: APB registers x_minimum, x_neutral, x_maximum, y_minimum,
// y_neutral, y_maximum at byte addresses 0x00..0x14, 12 bits each; write
// them only while no pair is in flight.
// Reset (rst_n low, asynchronous): pipeline emptied, registers return to
// their default calibration.
`timescale 1ns / 1ps
`include "joystick_axis_center_calibration_defines.svh"

module joystick_axis_center_calibration
    import jacc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] raw_x,
    input  logic [SAMPLE_BITS-1:0] raw_y,
    output logic                   done,
    output logic [SAMPLE_BITS-1:0] limited_x,
    output logic [SAMPLE_BITS-1:0] limited_y,
    output logic [SAMPLE_BITS-1:0] scaled_x,
    output logic [SAMPLE_BITS-1:0] scaled_y,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    cal_t     cal_reg;
    cal_t     cal_next;
    reg_idx_t reg_idx;
    logic     wr_en;
    fr_stat_t fr_stat;
    q_stat_t  q_stat;
    work_t    fr_word;
    work_t    q_word;
    logic     pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // register write decode
    always_comb
    begin
        cal_next = cal_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_X_MIN: cal_next.x_min = pwdata[SAMPLE_BITS-1:0];
                REG_X_NEU: cal_next.x_neu = pwdata[SAMPLE_BITS-1:0];
                REG_X_MAX: cal_next.x_max = pwdata[SAMPLE_BITS-1:0];
                REG_Y_MIN: cal_next.y_min = pwdata[SAMPLE_BITS-1:0];
                REG_Y_NEU: cal_next.y_neu = pwdata[SAMPLE_BITS-1:0];
                REG_Y_MAX: cal_next.y_max = pwdata[SAMPLE_BITS-1:0];
                default:   cal_next = cal_reg;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_X_MIN: prdata = DATA_W'(cal_reg.x_min);
            REG_X_NEU: prdata = DATA_W'(cal_reg.x_neu);
            REG_X_MAX: prdata = DATA_W'(cal_reg.x_max);
            REG_Y_MIN: prdata = DATA_W'(cal_reg.y_min);
            REG_Y_NEU: prdata = DATA_W'(cal_reg.y_neu);
            REG_Y_MAX: prdata = DATA_W'(cal_reg.y_max);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.x_min <= X_MIN_RST;
            cal_reg.x_neu <= X_NEU_RST;
            cal_reg.x_max <= X_MAX_RST;
            cal_reg.y_min <= Y_MIN_RST;
            cal_reg.y_neu <= Y_NEU_RST;
            cal_reg.y_max <= Y_MAX_RST;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    jacc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .raw_x   (raw_x),
        .raw_y   (raw_y),
        .cal     (cal_reg),
        .q_stat  (q_stat),
        .fr_stat (fr_stat),
        .word    (fr_word)
    );

    jacc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .fr_stat (fr_stat),
        .wr_word (fr_word),
        .pop     (pop),
        .rd_word (q_word),
        .q_stat  (q_stat)
    );

    jacc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_word   (q_word),
        .pop       (pop),
        .done      (done),
        .limited_x (limited_x),
        .limited_y (limited_y),
        .scaled_x  (scaled_x),
        .scaled_y  (scaled_y)
    );

    // an accepted pair is held by the front in the next cycle
    `JACC_ASSERT_NEXT(a_accept_held, start && !busy, fr_stat.valid, "accepted word not held")
    // busy only ever comes from a full queue
    `JACC_ASSERT_NOW(a_busy_full, busy, q_stat.full && fr_stat.valid, "busy without full queue")
    // full and empty never together
    `JACC_ASSERT_NOW(a_queue_flags, q_stat.full, !q_stat.empty, "queue full and empty")

endmodule
